### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MLP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define MLP_ASSERT(lbl, prop)
`define MLP_ASSERT_NEVER(lbl, expr)
`endif
`endif

### rtl/mlp_pkg.sv
// ---------------------------------------------------------------------------
// MLP package
// Payload types, command and register codes shared by the MLP block.
// ---------------------------------------------------------------------------
package mlp_pkg;

  localparam int VALUE_W    = 16;
  localparam int NODE_W     = 4;
  localparam int ACT_W      = 15;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int RESULT_CAP = 16;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_INPUT  = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 3'd3;

  typedef struct packed {
    cmd_t               command;
    logic [2:0]         layer;
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [ACT_W-1:0]  activation;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [4:0] input_count;
    logic [4:0] hidden_count;
    logic [2:0] hidden_layer_count;
    logic [4:0] output_count;
  } cfg_regs_t;

  typedef struct packed {
    logic acc_init;
    logic issue;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

### rtl/mlp_ram.sv
// ---------------------------------------------------------------------------
// MLP RAM
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/mlp_mac.sv
// ---------------------------------------------------------------------------
// MLP MAC unit
// Shared multiply-accumulate pipeline with ReLU and saturation of the sum.
// ---------------------------------------------------------------------------
module mlp_mac
  import mlp_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  parameter int WCOLS      = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mac_ctl_t                     ctl,
  input  logic signed [VALUE_BITS-1:0] bias_q,
  input  logic signed [VALUE_BITS-1:0] weight_q,
  input  logic signed [VALUE_BITS-1:0] src_q,
  output mac_sts_t                     sts,
  output logic [VALUE_BITS-1:0]        node_val
);

  localparam int ACC_W = 2 * VALUE_BITS + $clog2(WCOLS + 1) + 1;
  localparam logic signed [ACC_W-1:0] TOP = ACC_W'((1 << (VALUE_BITS - 1)) - 1);

  logic                           rd_vld_r;
  logic                           prod_vld_r;
  logic signed [2*VALUE_BITS-1:0] prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= ctl.issue;
      prod_vld_r <= rd_vld_r;
    end
    if (rd_vld_r) begin
      prod_r <= weight_q * src_q;
    end
    if (ctl.acc_init) begin
      acc_r <= ACC_W'(bias_q) <<< 8;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign sts.busy = rd_vld_r | prod_vld_r;
  assign quot     = acc_r >>> 8;

  always_comb begin
    if (acc_r < ACC_W'(256)) begin
      node_val = '0;
    end else if (quot > TOP) begin
      node_val = VALUE_BITS'(TOP);
    end else begin
      node_val = VALUE_BITS'(quot);
    end
  end

endmodule

### rtl/mlp_ctrl.sv
// ---------------------------------------------------------------------------
// MLP sequencer
// Walks layers, nodes and weights of a run and drives the MAC and stores.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlp_ctrl
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS        = 16,
  parameter int MAX_HIDDEN        = 16,
  parameter int MAX_HIDDEN_LAYERS = 4,
  parameter int MAX_OUTPUTS       = 16,
  parameter int VALUE_BITS        = 16,
  parameter int WROWS = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS,
  parameter int WCOLS = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN,
  parameter int NLAYERS = MAX_HIDDEN_LAYERS + 1,
  parameter int ABUF  = WROWS,
  parameter int WAW   = $clog2(NLAYERS * WROWS * WCOLS),
  parameter int BAW   = $clog2(NLAYERS * WROWS),
  parameter int IAW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  parameter int AAW   = $clog2(2 * ABUF)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_regs_t             cfg,
  input  logic                  run_start,
  output logic                  in_ready,
  output mac_ctl_t              mac_ctl,
  input  mac_sts_t              mac_sts,
  input  logic [VALUE_BITS-1:0] node_val,
  output logic                  src_is_input,
  output logic [WAW-1:0]        w_raddr,
  output logic [BAW-1:0]        b_raddr,
  output logic [IAW-1:0]        in_raddr,
  output logic [AAW-1:0]        act_raddr,
  output logic                  act_we,
  output logic [AAW-1:0]        act_waddr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int DIM_MAX0 = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int DIM_MAX  = (DIM_MAX0 > MAX_OUTPUTS) ? DIM_MAX0 : MAX_OUTPUTS;
  localparam int CNT_W    = $clog2(DIM_MAX + 1);
  localparam int LW       = $clog2(MAX_HIDDEN_LAYERS + 1);
  localparam int NO_MAX   = (MAX_OUTPUTS > RESULT_CAP) ? RESULT_CAP : MAX_OUTPUTS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t           state_r;
  logic [LW-1:0]    layer_r;
  logic [LW-1:0]    nl_r;
  logic [CNT_W-1:0] row_r;
  logic [CNT_W-1:0] col_r;
  logic [CNT_W-1:0] ni_r;
  logic [CNT_W-1:0] nh_r;
  logic [CNT_W-1:0] no_r;
  logic             acc_init_r;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             last_layer;
  logic [CNT_W-1:0] cols;

  assign last_layer = (layer_r == nl_r);
  assign cols       = (layer_r == '0) ? ni_r : nh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_init_r  <= 1'b0;
      out_valid_r <= 1'b0;
      layer_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      acc_init_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (run_start) begin
            ni_r <= (cfg.input_count == '0) ? CNT_W'(1) :
                    (int'(cfg.input_count) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) :
                    CNT_W'(cfg.input_count);
            nh_r <= (cfg.hidden_count == '0) ? CNT_W'(1) :
                    (int'(cfg.hidden_count) > MAX_HIDDEN) ? CNT_W'(MAX_HIDDEN) :
                    CNT_W'(cfg.hidden_count);
            no_r <= (cfg.output_count == '0) ? CNT_W'(1) :
                    (int'(cfg.output_count) > NO_MAX) ? CNT_W'(NO_MAX) :
                    CNT_W'(cfg.output_count);
            nl_r <= (cfg.hidden_layer_count == '0) ? LW'(1) :
                    (int'(cfg.hidden_layer_count) > MAX_HIDDEN_LAYERS) ?
                    LW'(MAX_HIDDEN_LAYERS) : LW'(cfg.hidden_layer_count);
            layer_r <= '0;
            row_r   <= '0;
            state_r <= S_BIAS;
          end
        end
        S_BIAS: begin
          col_r      <= '0;
          acc_init_r <= 1'b1;
          state_r    <= S_MAC;
        end
        S_MAC: begin
          if (col_r == cols - CNT_W'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            col_r <= col_r + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!mac_sts.busy) begin
            if (last_layer) begin
              out_r.node_index <= NODE_W'(row_r);
              out_r.activation <= ACT_W'(node_val);
              out_r.last       <= (row_r == no_r - CNT_W'(1));
              out_valid_r      <= 1'b1;
              state_r          <= S_EMIT;
            end else if (row_r == nh_r - CNT_W'(1)) begin
              row_r   <= '0;
              layer_r <= layer_r + LW'(1);
              state_r <= S_BIAS;
            end else begin
              row_r   <= row_r + CNT_W'(1);
              state_r <= S_BIAS;
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_r.last) begin
              state_r <= S_IDLE;
            end else begin
              row_r   <= row_r + CNT_W'(1);
              state_r <= S_BIAS;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign mac_ctl.acc_init = acc_init_r;
  assign mac_ctl.issue    = (state_r == S_MAC);
  assign src_is_input     = (layer_r == '0);
  assign w_raddr  = WAW'((int'(layer_r) * WROWS + int'(row_r)) * WCOLS + int'(col_r));
  assign b_raddr  = BAW'(int'(layer_r) * WROWS + int'(row_r));
  assign in_raddr = IAW'(col_r);
  assign act_raddr = AAW'((layer_r[0] ? 0 : ABUF) + int'(col_r));
  assign act_waddr = AAW'((layer_r[0] ? ABUF : 0) + int'(row_r));
  assign act_we    = (state_r == S_DRAIN) && !mac_sts.busy && !last_layer;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MLP_ASSERT(a_out_in_emit, out_valid_r |-> state_r == S_EMIT)
  `MLP_ASSERT(a_run_busy, run_start |=> !in_ready)
  `MLP_ASSERT_NEVER(a_no_act_wr_last, act_we && last_layer)
  `MLP_ASSERT(a_last_frees, (out_valid_r && out_ready && out_r.last) |=> in_ready)

endmodule

### rtl/mlp_relu_forward_pass.sv
// ---------------------------------------------------------------------------
// MLP ReLU forward pass
// Dense multilayer perceptron inference with ReLU on every layer.
// ---------------------------------------------------------------------------
//   port group | direction | carries
//   in_*       | input     | load weight / bias / input element, or run
//   out_*      | output    | one output node activation, last flags end
//   cfg_*      | input     | node and layer counts, one write per cycle
//
// A run walks every node of all layers and emits each output node in turn;
// one shared MAC pipeline consumes one weight per cycle. Stores need no
// clearing pass after reset. Input is held off during a run; a stalled
// output holds the sequencer until the request is taken.
// ---------------------------------------------------------------------------
module mlp_relu_forward_pass
  import mlp_pkg::*;
#(
  parameter int MAX_INPUTS        = 16,
  parameter int MAX_HIDDEN        = 16,
  parameter int MAX_HIDDEN_LAYERS = 4,
  parameter int MAX_OUTPUTS       = 16,
  parameter int VALUE_BITS        = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int WROWS   = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int WCOLS   = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int NLAYERS = MAX_HIDDEN_LAYERS + 1;
  localparam int ABUF    = WROWS;
  localparam int WAW     = $clog2(NLAYERS * WROWS * WCOLS);
  localparam int BAW     = $clog2(NLAYERS * WROWS);
  localparam int IAW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int AAW     = $clog2(2 * ABUF);

  cfg_regs_t                    cfg_r;
  logic                         accept;
  logic                         run_start;
  logic                         in_range_lr;
  logic                         w_we;
  logic                         b_we;
  logic                         i_we;
  logic [VALUE_BITS-1:0]        load_val;
  logic [WAW-1:0]               w_waddr;
  logic [BAW-1:0]               b_waddr;
  logic [WAW-1:0]               w_raddr;
  logic [BAW-1:0]               b_raddr;
  logic [IAW-1:0]               in_raddr;
  logic [AAW-1:0]               act_raddr;
  logic [AAW-1:0]               act_waddr;
  logic                         act_we;
  logic                         src_is_input;
  logic signed [VALUE_BITS-1:0] weight_q;
  logic signed [VALUE_BITS-1:0] bias_q;
  logic signed [VALUE_BITS-1:0] input_q;
  logic signed [VALUE_BITS-1:0] act_q;
  logic signed [VALUE_BITS-1:0] src_q;
  logic [VALUE_BITS-1:0]        node_val;
  mac_ctl_t                     mac_ctl;
  mac_sts_t                     mac_sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_count        <= 5'd16;
      cfg_r.hidden_count       <= 5'd16;
      cfg_r.hidden_layer_count <= 3'd1;
      cfg_r.output_count       <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT:  cfg_r.input_count        <= cfg_data;
        CFG_HIDDEN_COUNT: cfg_r.hidden_count       <= cfg_data;
        CFG_LAYER_COUNT:  cfg_r.hidden_layer_count <= cfg_data[2:0];
        CFG_OUTPUT_COUNT: cfg_r.output_count       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept      = in_valid && in_ready;
  assign run_start   = accept && (in_data.command == CMD_RUN);
  assign in_range_lr = (int'(in_data.layer) < NLAYERS) && (int'(in_data.row) < WROWS);
  assign w_we = accept && (in_data.command == CMD_WEIGHT) && in_range_lr &&
                (int'(in_data.column) < WCOLS);
  assign b_we = accept && (in_data.command == CMD_BIAS) && in_range_lr;
  assign i_we = accept && (in_data.command == CMD_INPUT) &&
                (int'(in_data.row) < MAX_INPUTS);
  assign load_val = VALUE_BITS'($unsigned(in_data.value));
  assign w_waddr  = WAW'((int'(in_data.layer) * WROWS + int'(in_data.row)) * WCOLS +
                         int'(in_data.column));
  assign b_waddr  = BAW'(int'(in_data.layer) * WROWS + int'(in_data.row));
  assign src_q    = src_is_input ? input_q : act_q;

  mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(NLAYERS * WROWS * WCOLS), .AW(WAW)) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (load_val),
    .rd_addr (w_raddr),
    .rd_data (weight_q)
  );

  mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(NLAYERS * WROWS), .AW(BAW)) u_bias_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (b_waddr),
    .wr_data (load_val),
    .rd_addr (b_raddr),
    .rd_data (bias_q)
  );

  mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_INPUTS), .AW(IAW)) u_input_ram (
    .clk     (clk),
    .wr_en   (i_we),
    .wr_addr (IAW'(in_data.row)),
    .wr_data (load_val),
    .rd_addr (in_raddr),
    .rd_data (input_q)
  );

  mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(2 * ABUF), .AW(AAW)) u_act_ram (
    .clk     (clk),
    .wr_en   (act_we),
    .wr_addr (act_waddr),
    .wr_data (node_val),
    .rd_addr (act_raddr),
    .rd_data (act_q)
  );

  mlp_mac #(.VALUE_BITS(VALUE_BITS), .WCOLS(WCOLS)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .bias_q   (bias_q),
    .weight_q (weight_q),
    .src_q    (src_q),
    .sts      (mac_sts),
    .node_val (node_val)
  );

  mlp_ctrl #(
    .MAX_INPUTS        (MAX_INPUTS),
    .MAX_HIDDEN        (MAX_HIDDEN),
    .MAX_HIDDEN_LAYERS (MAX_HIDDEN_LAYERS),
    .MAX_OUTPUTS       (MAX_OUTPUTS),
    .VALUE_BITS        (VALUE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .run_start    (run_start),
    .in_ready     (in_ready),
    .mac_ctl      (mac_ctl),
    .mac_sts      (mac_sts),
    .node_val     (node_val),
    .src_is_input (src_is_input),
    .w_raddr      (w_raddr),
    .b_raddr      (b_raddr),
    .in_raddr     (in_raddr),
    .act_raddr    (act_raddr),
    .act_we       (act_we),
    .act_waddr    (act_waddr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
